[design/rcpf_pkg.sv]
// Shared types, constants and helper functions of the pixel format converter.
`timescale 1ns / 1ps

package rcpf_pkg;

   // Field and counter widths.
   localparam int CHAN_W    = 8;
   localparam int DIM_W     = 13;
   localparam int CNT_W     = 12;
   localparam int PIXEL_W   = 32;
   localparam int OFFSET_W  = 26;
   localparam int PROD_W    = 2 * DIM_W;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 64;

   // Default frame size limits for the top-level parameters.
   localparam int MAX_WIDTH_DEFAULT  = 4096;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   // Register reset values.
   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

   // Client pixel formats.
   typedef enum logic [1:0] {
      FMT_RGB222   = 2'd0,
      FMT_RED_LOW  = 2'd1,
      FMT_BLUE_LOW = 2'd2,
      FMT_INVALID  = 2'd3
   } fmt_type;

   // Frame settings seen by the back end.
   typedef struct packed {
      fmt_type          fmt;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } cfg_type;

   // One classified pixel travelling from front to back.
   typedef struct packed {
      fmt_type           fmt;
      logic [CNT_W-1:0]  col;
      logic [CNT_W-1:0]  row;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
   } entry_type;

   // Zero becomes one, and anything above the limit becomes the limit.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W:0]   maxv);
      logic [DIM_W-1:0] res;
      if (v == '0) begin
         res = DIM_W'(1);
      end else if ({1'b0, v} > maxv) begin
         res = maxv[DIM_W-1:0];
      end else begin
         res = v;
      end
      return res;
   endfunction

   // Channel times 3 over 255, truncated: thresholds at 85, 170 and 255.
   function automatic logic [1:0] scale_to_2bit(input logic [CHAN_W-1:0] c);
      logic [1:0] res;
      if (c == 8'd255) begin
         res = 2'd3;
      end else if (c >= 8'd170) begin
         res = 2'd2;
      end else if (c >= 8'd85) begin
         res = 2'd1;
      end else begin
         res = 2'd0;
      end
      return res;
   endfunction

endpackage

[design/rgba_to_client_pixel_flip_core.sv]
// Top level of the RGBA to client pixel format converter with vertical flip.
`timescale 1ns / 1ps

// Converts one RGBA pixel per request, in raster order, to an rgb222 byte or a
// 32-bit word with red or blue in the low byte, and gives the byte offset of the
// pixel in a vertically flipped frame. The block takes one request per clock and
// gives one response per clock while the queue is not full and the output is not
// stalled; each response passes the queue, stage one and the result register.
// The rate is set by the frame position counters in the front end; a four-entry
// queue separates them from the two-stage back end, whose first stage holds the
// row-times-width multiplier. Register writes are for the user to make only while
// idle, unenforced; a width or height write restarts the frame at its first pixel.
module rgba_to_client_pixel_flip_core #(
   parameter int MAX_WIDTH  = rcpf_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = rcpf_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rcpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rcpf_pkg::DIM_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  logic [rcpf_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_pixel [31:0], byte_offset [57:32], zeros [63:58]
   output logic [rcpf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // out_valid [0]
   output logic                              rsp_tuser,
   // frame_end
   output logic                              rsp_tlast
);
   import rcpf_pkg::*;

   logic      push, queue_full, pop, not_empty;
   entry_type push_entry, head;
   cfg_type   cfg;

   rcpf_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry),
      .cfg        (cfg)
   );

   rcpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head)
   );

   rcpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .not_empty  (not_empty),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[design/rcpf_front.sv]
// Front end: configuration registers, frame position counters and pixel classification.
`timescale 1ns / 1ps

module rcpf_front #(
   parameter int MAX_WIDTH  = rcpf_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = rcpf_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rcpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rcpf_pkg::DIM_W-1:0]           csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [rcpf_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 queue_full,
   output logic                                 push,
   output rcpf_pkg::entry_type                  push_entry,
   output rcpf_pkg::cfg_type                    cfg
);
   import rcpf_pkg::*;

   localparam logic [DIM_W:0] MAX_W = (DIM_W+1)'(MAX_WIDTH);
   localparam logic [DIM_W:0] MAX_H = (DIM_W+1)'(MAX_HEIGHT);

   fmt_type          fmt_ff, fmt_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [CNT_W-1:0] column_count_ff, column_count_in;
   logic [CNT_W-1:0] row_count_ff, row_count_in;

   logic [DIM_W-1:0] col, row, col_inc, row_inc;
   logic             accept;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Keep the position inside the frame and find the last pixel.
   always_comb begin
      col     = ({1'b0, column_count_ff} >= width_ff) ? '0 : {1'b0, column_count_ff};
      row     = ({1'b0, row_count_ff} >= height_ff) ? '0 : {1'b0, row_count_ff};
      col_inc = col + DIM_W'(1);
      row_inc = row + DIM_W'(1);

      push             = accept;
      push_entry.fmt   = fmt_ff;
      push_entry.col   = col[CNT_W-1:0];
      push_entry.row   = row[CNT_W-1:0];
      push_entry.red   = req_tdata[CHAN_W-1:0];
      push_entry.green = req_tdata[2*CHAN_W-1:CHAN_W];
      push_entry.blue  = req_tdata[3*CHAN_W-1:2*CHAN_W];
      push_entry.last  = (col == width_ff - DIM_W'(1)) && (row == height_ff - DIM_W'(1));
   end

   // Register writes take priority; a geometry write restarts the frame.
   always_comb begin
      fmt_in          = fmt_ff;
      width_in        = width_ff;
      height_in       = height_ff;
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PIXEL_FORMAT: begin
               fmt_in = fmt_type'(csr_wdata[1:0]);
            end
            REG_FRAME_WIDTH: begin
               width_in        = clamp_dim(csr_wdata, MAX_W);
               column_count_in = '0;
               row_count_in    = '0;
            end
            REG_FRAME_HEIGHT: begin
               height_in       = clamp_dim(csr_wdata, MAX_H);
               column_count_in = '0;
               row_count_in    = '0;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (col_inc >= width_ff) begin
            column_count_in = '0;
            row_count_in    = (row_inc >= height_ff) ? '0 : row_inc[CNT_W-1:0];
         end else begin
            column_count_in = col_inc[CNT_W-1:0];
            row_count_in    = row[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff          <= FMT_RGB222;
         width_ff        <= clamp_dim(WIDTH_RESET, MAX_W);
         height_ff       <= clamp_dim(HEIGHT_RESET, MAX_H);
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         fmt_ff          <= fmt_in;
         width_ff        <= width_in;
         height_ff       <= height_in;
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   assign cfg.fmt    = fmt_ff;
   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

endmodule

[design/rcpf_queue.sv]
// Short first-in first-out queue of classified pixels between front and back.
`timescale 1ns / 1ps

module rcpf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rcpf_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output rcpf_pkg::entry_type head
);
   import rcpf_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[design/rcpf_back.sv]
// Back end: channel scaling, packing and flipped byte offset, in two stages.
`timescale 1ns / 1ps

module rcpf_back (
   input  logic                                clock,
   input  logic                                reset,
   input  rcpf_pkg::cfg_type                   cfg,
   input  logic                                not_empty,
   input  rcpf_pkg::entry_type                 head,
   output logic                                pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rcpf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import rcpf_pkg::*;

   // Stage one: product of the flipped row and the width, and the packed pixel.
   logic                s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]   s1_prod_ff, s1_prod_in;
   logic [CNT_W-1:0]    s1_col_ff;
   logic [PIXEL_W-1:0]  s1_pix_ff, s1_pix_in;
   fmt_type             s1_fmt_ff;
   logic                s1_last_ff;

   // Stage two: the result register.
   logic                out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]  out_pixel_ff, out_pixel_in;
   logic [OFFSET_W-1:0] out_offset_ff, out_offset_in;
   logic                out_flag_ff;
   logic                out_last_ff;

   logic                s2_advance, s1_advance;
   logic [DIM_W-1:0]    flipped_row;
   logic [PROD_W:0]     linear;

   assign s2_advance  = !out_valid_ff || rsp_tready;
   assign s1_advance  = !s1_valid_ff || s2_advance;
   assign pop         = s1_advance && not_empty;
   assign s1_valid_in = s1_advance ? not_empty : s1_valid_ff;
   assign out_valid_in = s2_advance ? s1_valid_ff : out_valid_ff;

   // Flipped row times width, and the pixel packed in the client format.
   always_comb begin
      flipped_row = cfg.height - DIM_W'(1) - {1'b0, head.row};
      s1_prod_in  = {{DIM_W{1'b0}}, flipped_row} * {{DIM_W{1'b0}}, cfg.width};
      unique case (head.fmt)
         FMT_RGB222: begin
            s1_pix_in = {26'd0, scale_to_2bit(head.red), scale_to_2bit(head.green),
                         scale_to_2bit(head.blue)};
         end
         FMT_RED_LOW: begin
            s1_pix_in = {8'd0, head.blue, head.green, head.red};
         end
         FMT_BLUE_LOW: begin
            s1_pix_in = {8'd0, head.red, head.green, head.blue};
         end
         default: begin
            s1_pix_in = '0;
         end
      endcase
   end

   // Add the column and scale by bytes per pixel.
   always_comb begin
      linear = {1'b0, s1_prod_ff} + {{(PROD_W+1-CNT_W){1'b0}}, s1_col_ff};
      unique case (s1_fmt_ff)
         FMT_RGB222: begin
            out_offset_in = linear[OFFSET_W-1:0];
         end
         FMT_RED_LOW, FMT_BLUE_LOW: begin
            out_offset_in = {linear[OFFSET_W-3:0], 2'b00};
         end
         default: begin
            out_offset_in = '0;
         end
      endcase
      out_pixel_in = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         s1_prod_ff <= s1_prod_in;
         s1_col_ff  <= head.col;
         s1_pix_ff  <= s1_pix_in;
         s1_fmt_ff  <= head.fmt;
         s1_last_ff <= head.last;
      end
      if (s2_advance) begin
         out_pixel_ff  <= out_pixel_in;
         out_offset_ff <= out_offset_in;
         out_flag_ff   <= (s1_fmt_ff != FMT_INVALID);
         out_last_ff   <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-PIXEL_W-OFFSET_W){1'b0}}, out_offset_ff, out_pixel_ff};
   assign rsp_tuser  = out_flag_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

[bench/client_pixel_checker.sv]
// Checker that predicts and compares every response of the pixel format converter.
`timescale 1ns / 1ps

module client_pixel_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rcpf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rcpf_pkg::DIM_W-1:0]        csr_wdata,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  logic [rcpf_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_pixel [31:0], byte_offset [57:32], zeros [63:58]
   input  logic [rcpf_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // out_valid [0]
   input  logic                              rsp_tuser,
   // frame_end
   input  logic                              rsp_tlast,
   output int                                mismatch_count,
   output int                                pending_count,
   output int                                result_count,
   output int                                frame_end_count
);
   import rcpf_pkg::*;

   // One converted pixel as it should leave the block.
   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic [OFFSET_W-1:0] offset;
      logic                valid;
      logic                last;
   } flipped_pixel_type;

   flipped_pixel_type expected_q[$];
   fmt_type           cur_fmt;
   logic [DIM_W-1:0]  width_reg;
   logic [DIM_W-1:0]  height_reg;
   int unsigned       col_pos;
   int unsigned       row_pos;
   int                mismatch_total;
   int                result_total;
   int                frame_end_total;

   // Zero counts as one, and anything above the limit counts as the limit.
   function automatic int unsigned frame_dim(input logic [DIM_W-1:0] v,
                                             input int unsigned maxv);
      if (v == '0) begin
         return 1;
      end else if (v > maxv) begin
         return maxv;
      end
      return v;
   endfunction

   // Scales a channel byte down to 0..3 with truncation.
   function automatic logic [1:0] to_two_bits(input logic [CHAN_W-1:0] c);
      int unsigned prod;
      prod = (int'(c) * 3) / 255;
      return prod[1:0];
   endfunction

   // Packs one pixel and places it in the vertically flipped frame.
   function automatic flipped_pixel_type convert_pixel(input fmt_type f,
                                                       input int unsigned w,
                                                       input int unsigned h,
                                                       input int unsigned col,
                                                       input int unsigned row,
                                                       input logic [CHAN_W-1:0] r,
                                                       input logic [CHAN_W-1:0] g,
                                                       input logic [CHAN_W-1:0] b);
      flipped_pixel_type res;
      int unsigned       bpp;
      int unsigned       off;
      res = '0;
      bpp = 0;
      case (f)
         FMT_RGB222: begin
            res.pixel = {26'd0, to_two_bits(r), to_two_bits(g), to_two_bits(b)};
            res.valid = 1'b1;
            bpp = 1;
         end
         FMT_RED_LOW: begin
            res.pixel = {8'd0, b, g, r};
            res.valid = 1'b1;
            bpp = 4;
         end
         FMT_BLUE_LOW: begin
            res.pixel = {8'd0, r, g, b};
            res.valid = 1'b1;
            bpp = 4;
         end
         default: begin
         end
      endcase
      if (res.valid) begin
         off = ((h - 1 - row) * w + col) * bpp;
         res.offset = off[OFFSET_W-1:0];
      end
      res.last = (col == w - 1) && (row == h - 1);
      return res;
   endfunction

   // Counts a field mismatch and reports it.
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_total++;
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
   endtask

   // Track register writes and requests, and compare each response.
   always @(posedge clock) begin
      flipped_pixel_type seen;
      flipped_pixel_type want;
      int unsigned       w;
      int unsigned       h;
      int unsigned       col;
      int unsigned       row;
      if (reset) begin
         cur_fmt = FMT_RGB222;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         col_pos = 0;
         row_pos = 0;
         expected_q.delete();
         mismatch_total = 0;
         result_total = 0;
         frame_end_total = 0;
      end else begin
         // A width or height write starts a new frame.
         if (csr_we) begin
            case (csr_index)
               REG_PIXEL_FORMAT: begin
                  cur_fmt = fmt_type'(csr_wdata[1:0]);
               end
               REG_FRAME_WIDTH: begin
                  width_reg = csr_wdata;
                  col_pos = 0;
                  row_pos = 0;
               end
               REG_FRAME_HEIGHT: begin
                  height_reg = csr_wdata;
                  col_pos = 0;
                  row_pos = 0;
               end
               default: begin
               end
            endcase
         end

         // Compare an accepted response with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            seen.pixel = rsp_tdata[31:0];
            seen.offset = rsp_tdata[57:32];
            seen.valid = rsp_tuser;
            seen.last = rsp_tlast;
            result_total++;
            if (seen.last === 1'b1) begin
               frame_end_total++;
            end
            if (expected_q.size() == 0) begin
               mismatch_total++;
               $error("response with no request outstanding: data 0x%0h", rsp_tdata);
            end else begin
               want = expected_q.pop_front();
               check_field("out_pixel", want.pixel, seen.pixel);
               check_field("byte_offset", 32'(want.offset), 32'(seen.offset));
               check_field("out_valid", 32'(want.valid), 32'(seen.valid));
               check_field("frame_end", 32'(want.last), 32'(seen.last));
            end
         end

         // Predict the response of an accepted request and step the position.
         if (req_tvalid && req_tready) begin
            w = frame_dim(width_reg, MAX_WIDTH_DEFAULT);
            h = frame_dim(height_reg, MAX_HEIGHT_DEFAULT);
            col = (col_pos >= w) ? 0 : col_pos;
            row = (row_pos >= h) ? 0 : row_pos;
            expected_q.push_back(convert_pixel(cur_fmt, w, h, col, row, req_tdata[7:0],
                                               req_tdata[15:8], req_tdata[23:16]));
            if (col + 1 >= w) begin
               col = 0;
               row = (row + 1 >= h) ? 0 : row + 1;
            end else begin
               col = col + 1;
            end
            col_pos = col & 32'hFFF;
            row_pos = row & 32'hFFF;
         end
      end
      pending_count <= expected_q.size();
      mismatch_count <= mismatch_total;
      result_count <= result_total;
      frame_end_count <= frame_end_total;
   end

endmodule

[bench/rgba_to_client_pixel_flip_core_tb.sv]
// Testbench top that drives pixel requests and register writes and gives the verdict.
`timescale 1ns / 1ps

module rgba_to_client_pixel_flip_core_tb;
   import rcpf_pkg::*;

   localparam int RANDOM_ITEMS = 1700;
   localparam int TAIL_ITEMS   = 250;

   // Register index that names no register.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [DIM_W-1:0]      csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   int mismatch_count;
   int pending_count;
   int result_count;
   int frame_end_count;
   int pixels_sent;
   int settings_used;
   bit quiet_tail;

   rgba_to_client_pixel_flip_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   client_pixel_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .result_count    (result_count),
      .frame_end_count (frame_end_count)
   );

   // Clock with a 2 ns period.
   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard limit on the run time.
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // The receiver stalls in random bursts, except in the tail of the run.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(40, 120)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
         if (!quiet_tail && $urandom_range(0, 1) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
      end
   end

   // Sends one pixel request and returns at the edge that accepts it.
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      req_tvalid <= 1'b1;
      req_tdata <= {blue, green, red};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pixels_sent++;
   endtask

   // Drops the request line and waits until every response has come back.
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Puts one register write on the port; the caller lowers csr_we afterwards.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Channel byte, often right at a scaling threshold.
   function automatic logic [7:0] pick_chan;
      logic [7:0] marks [7];
      marks = '{8'd0, 8'd84, 8'd85, 8'd169, 8'd170, 8'd254, 8'd255};
      if ($urandom_range(0, 3) == 0) begin
         return marks[$urandom_range(0, 6)];
      end
      return 8'($urandom);
   endfunction

   // Frame dimension, mostly small, with the extremes now and then.
   function automatic logic [DIM_W-1:0] pick_dim;
      int k;
      k = $urandom_range(0, 19);
      if (k == 0) begin
         return '0;
      end else if (k == 1) begin
         return DIM_W'(4096);
      end else if (k == 2) begin
         return DIM_W'($urandom_range(4097, 8191));
      end else if (k == 3) begin
         return DIM_W'($urandom_range(1, 4096));
      end else if (k < 8) begin
         return DIM_W'($urandom_range(9, 64));
      end
      return DIM_W'($urandom_range(1, 8));
   endfunction

   // Stimulus: directed pixels first, then random settings and pixel runs.
   initial begin
      int               target;
      int               run_len;
      bit               steady;
      fmt_type          fmt;
      logic [DIM_W-1:0] fmt_word;

      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= REG_PIXEL_FORMAT;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      quiet_tail = 1'b0;
      pixels_sent = 0;
      settings_used = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Small 3x2 frame in rgb222, with channels on each side of the thresholds.
      write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_RGB222));
      write_reg(REG_FRAME_WIDTH, DIM_W'(3));
      write_reg(REG_FRAME_HEIGHT, DIM_W'(2));
      csr_we <= 1'b0;
      settings_used++;
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd84, 8'd85, 8'd169);
      send_pixel(8'd170, 8'd254, 8'd255);
      send_pixel(8'd85, 8'd170, 8'd84);
      send_pixel(8'd1, 8'd2, 8'd4);

      // Hold the sender until the block has emptied.
      drain();

      // Both 32-bit layouts; the frame position carries on across the format change.
      write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_RED_LOW));
      csr_we <= 1'b0;
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'hAA, 8'h55, 8'h5A);
      drain();
      write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_BLUE_LOW));
      csr_we <= 1'b0;
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'h55, 8'hAA, 8'hA5);
      drain();

      // Invalid format still moves the frame position.
      write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_INVALID));
      csr_we <= 1'b0;
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd12, 8'd34, 8'd56);
      send_pixel(8'd0, 8'd0, 8'd0);
      drain();

      // Zero width and an oversized height are clamped; the unused index is ignored.
      write_reg(REG_PIXEL_FORMAT, DIM_W'(FMT_RED_LOW));
      write_reg(REG_FRAME_WIDTH, '0);
      write_reg(REG_FRAME_HEIGHT, DIM_W'(8191));
      write_reg(REG_UNUSED, DIM_W'(8191));
      csr_we <= 1'b0;
      settings_used++;
      send_pixel(8'd1, 8'd2, 8'd3);
      send_pixel(8'd4, 8'd5, 8'd6);
      send_pixel(8'd7, 8'd8, 8'd9);
      drain();

      // Oversized width and zero height.
      write_reg(REG_FRAME_WIDTH, DIM_W'(8191));
      write_reg(REG_FRAME_HEIGHT, '0);
      csr_we <= 1'b0;
      settings_used++;
      send_pixel(8'd9, 8'd8, 8'd7);
      send_pixel(8'd6, 8'd5, 8'd4);
      send_pixel(8'd3, 8'd2, 8'd1);
      drain();

      // Random settings, each followed by a run of random pixels.
      target = pixels_sent + RANDOM_ITEMS;
      while (pixels_sent < target) begin
         quiet_tail = (pixels_sent >= target - TAIL_ITEMS);

         if ($urandom_range(0, 5) == 0) begin
            fmt = FMT_INVALID;
         end else begin
            fmt = fmt_type'($urandom_range(0, 2));
         end
         fmt_word = DIM_W'($urandom);
         fmt_word[1:0] = fmt;
         write_reg(REG_PIXEL_FORMAT, fmt_word);
         if ($urandom_range(0, 3) != 0) begin
            write_reg(REG_FRAME_WIDTH, pick_dim());
            if ($urandom_range(0, 4) != 0) begin
               write_reg(REG_FRAME_HEIGHT, pick_dim());
            end
         end
         if ($urandom_range(0, 7) == 0) begin
            write_reg(REG_UNUSED, DIM_W'($urandom));
         end
         csr_we <= 1'b0;
         settings_used++;

         steady = quiet_tail || ($urandom_range(0, 3) == 0);
         run_len = $urandom_range(10, 120);
         repeat (run_len) begin
            if (!steady && $urandom_range(0, 149) == 0) begin
               drain();
            end else if (!steady && $urandom_range(0, 4) == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 14)) @(posedge clock);
            end
            send_pixel(pick_chan(), pick_chan(), pick_chan());
         end
         drain();
      end

      // Let any stray response show up before the verdict.
      repeat (20) @(posedge clock);
      $display("Sent %0d pixels under %0d frame and format settings.", pixels_sent,
               settings_used);
      $display("Checked %0d responses, %0d of them frame ends.", result_count,
               frame_end_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
